// ===== src/line_follow_steering_top_macros.svh =====
// assertion macros for the line follow steering checker
`ifndef LINE_FOLLOW_STEERING_TOP_MACROS_SVH
`define LINE_FOLLOW_STEERING_TOP_MACROS_SVH

// consequent must hold in the same cycle as the antecedent
`define LFS_ASSERT_SAME(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// consequent must hold in the cycle after the antecedent
`define LFS_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== src/lfs_pkg.sv =====
// types, codes and constants of the line follow steering block
package lfs_pkg;

   // sample and time widths
   localparam int LFS_LEVEL_W = 10;
   localparam int LFS_TIME_W  = 32;

   // request item layout: right, middle, left, now_ms from the lowest bit up
   localparam int LFS_REQ_RIGHT_LO  = 0;
   localparam int LFS_REQ_MIDDLE_LO = LFS_REQ_RIGHT_LO + LFS_LEVEL_W;
   localparam int LFS_REQ_LEFT_LO   = LFS_REQ_MIDDLE_LO + LFS_LEVEL_W;
   localparam int LFS_REQ_NOW_LO    = LFS_REQ_LEFT_LO + LFS_LEVEL_W;
   localparam int LFS_REQ_USED_W    = LFS_REQ_NOW_LO + LFS_TIME_W;
   localparam int LFS_REQ_W         = ((LFS_REQ_USED_W + 7) / 8) * 8;

   // response item layout: drive, fork_turn, route_done, line_seen
   localparam int LFS_RSP_DRIVE_LO = 0;
   localparam int LFS_RSP_FORK_LO  = 2;
   localparam int LFS_RSP_DONE_BIT = 4;
   localparam int LFS_RSP_SEEN_LO  = 5;
   localparam int LFS_RSP_W        = 8;

   // detection bit positions in line_seen
   localparam int LFS_SEEN_RIGHT  = 0;
   localparam int LFS_SEEN_MIDDLE = 1;
   localparam int LFS_SEEN_LEFT   = 2;

   // drive codes
   localparam logic [1:0] LFS_DRV_STOP  = 2'd0;
   localparam logic [1:0] LFS_DRV_FWD   = 2'd1;
   localparam logic [1:0] LFS_DRV_RIGHT = 2'd2;
   localparam logic [1:0] LFS_DRV_LEFT  = 2'd3;

   // fork decision codes
   localparam logic [1:0] LFS_FORK_NONE  = 2'd0;
   localparam logic [1:0] LFS_FORK_LEFT  = 2'd1;
   localparam logic [1:0] LFS_FORK_RIGHT = 2'd2;

   // register indexes on the csr port
   localparam int LFS_CSR_IDX_W = 3;
   localparam logic [LFS_CSR_IDX_W-1:0] LFS_CSR_DETECT_LOW  = 3'd0;
   localparam logic [LFS_CSR_IDX_W-1:0] LFS_CSR_DETECT_HIGH = 3'd1;
   localparam logic [LFS_CSR_IDX_W-1:0] LFS_CSR_TRACK_EN    = 3'd2;
   localparam logic [LFS_CSR_IDX_W-1:0] LFS_CSR_ROUTE_EN    = 3'd3;
   localparam logic [LFS_CSR_IDX_W-1:0] LFS_CSR_ROUTE_LEN   = 3'd4;
   localparam logic [LFS_CSR_IDX_W-1:0] LFS_CSR_ROUTE_TURNS = 3'd5;
   localparam logic [LFS_CSR_IDX_W-1:0] LFS_CSR_HOLDOFF     = 3'd6;
   localparam int LFS_CSR_DATA_W = 10;

   // register reset values
   localparam logic [9:0] LFS_RST_DETECT_LOW  = 10'd0;
   localparam logic [9:0] LFS_RST_DETECT_HIGH = 10'd1023;
   localparam logic [3:0] LFS_RST_ROUTE_LEN   = 4'd0;
   localparam logic [7:0] LFS_RST_ROUTE_TURNS = 8'd6;
   localparam logic [7:0] LFS_RST_HOLDOFF     = 8'd50;

   // route limits: longest route and width that holds it
   localparam int LFS_ROUTE_MAX = 8;
   localparam int LFS_LEN_W     = 5;
   localparam logic [7:0] LFS_HOLD_SAT = 8'hFF;

   // blind scan timing in ms since the scan started
   localparam logic [LFS_TIME_W-1:0] LFS_SCAN_SWING_LEFT  = 32'd200;
   localparam logic [LFS_TIME_W-1:0] LFS_SCAN_SWING_RIGHT = 32'd1600;
   localparam logic [LFS_TIME_W-1:0] LFS_SCAN_SWING_END   = 32'd2000;
   localparam logic [LFS_TIME_W-1:0] LFS_SCAN_STOP_LO     = 32'd3000;
   localparam logic [LFS_TIME_W-1:0] LFS_SCAN_STOP_HI     = 32'd3500;

   // configuration register set
   typedef struct packed {
      logic [LFS_LEVEL_W-1:0] detect_low;
      logic [LFS_LEVEL_W-1:0] detect_high;
      logic                   tracking_enable;
      logic                   route_enable;
      logic [3:0]             route_length;
      logic [7:0]             route_turns;
      logic [7:0]             fork_holdoff;
   } lfs_cfg_type;

   // per-item decision from the steering core
   typedef struct packed {
      logic [1:0] drive;
      logic [1:0] fork_turn;
      logic       route_done;
   } lfs_result_type;

endpackage

// ===== src/lfs_window.sv =====
// window compare of the three reflectance samples
module lfs_window
   import lfs_pkg::*;
(
   input  logic [LFS_LEVEL_W-1:0] right_level,
   input  logic [LFS_LEVEL_W-1:0] middle_level,
   input  logic [LFS_LEVEL_W-1:0] left_level,
   input  logic [LFS_LEVEL_W-1:0] detect_low,
   input  logic [LFS_LEVEL_W-1:0] detect_high,
   output logic [2:0]             line_seen
);

   // inclusive window, an inverted window detects nothing
   always_comb begin
      line_seen = '0;
      line_seen[LFS_SEEN_RIGHT]  = (right_level >= detect_low) && (right_level <= detect_high);
      line_seen[LFS_SEEN_MIDDLE] = (middle_level >= detect_low)
                                   && (middle_level <= detect_high);
      line_seen[LFS_SEEN_LEFT]   = (left_level >= detect_low) && (left_level <= detect_high);
   end

endmodule

// ===== src/lfs_core.sv =====
// steering state: sensor priority, blind scan and route fork turns
module lfs_core
   import lfs_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  step,
   input  logic [2:0]            line_seen,
   input  logic [LFS_TIME_W-1:0] now_ms,
   input  lfs_cfg_type           cfg,
   output lfs_result_type        res
);

   logic                  scan_armed_ff, scan_armed_in;
   logic                  scan_active_ff, scan_active_in;
   logic [LFS_TIME_W-1:0] scan_start_ff, scan_start_in;
   logic [3:0]            turn_index_ff, turn_index_in;
   logic [7:0]            holdoff_ff, holdoff_in;
   logic [1:0]            last_drive_ff, last_drive_in;
   logic [LFS_LEN_W-1:0]  len_eff;
   logic [LFS_TIME_W-1:0] start_eff;
   logic [LFS_TIME_W-1:0] elapsed;
   logic [1:0]            drive_v;
   logic [1:0]            fork_v;
   logic                  turn_bit;
   logic                  at_fork;

   // route length clipped to the longest route
   assign len_eff = ({1'b0, cfg.route_length} > LFS_LEN_W'(LFS_ROUTE_MAX))
                    ? LFS_LEN_W'(LFS_ROUTE_MAX) : {1'b0, cfg.route_length};

   // turn indexes of eight and above read as left
   assign turn_bit = !turn_index_ff[3] && cfg.route_turns[turn_index_ff[2:0]];

   assign at_fork = cfg.route_enable && ({1'b0, turn_index_ff} < len_eff)
                    && line_seen[LFS_SEEN_LEFT] && line_seen[LFS_SEEN_RIGHT];

   // next state and decision for the current item
   always_comb begin
      scan_armed_in  = scan_armed_ff;
      scan_active_in = scan_active_ff;
      scan_start_in  = scan_start_ff;
      turn_index_in  = turn_index_ff;
      holdoff_in     = holdoff_ff;
      drive_v        = LFS_DRV_STOP;
      fork_v         = LFS_FORK_NONE;
      start_eff      = scan_armed_ff ? now_ms : scan_start_ff;
      elapsed        = now_ms - start_eff;

      if (cfg.tracking_enable) begin
         // fork handling with holdoff count
         if (at_fork) begin
            if (holdoff_ff > cfg.fork_holdoff) begin
               fork_v        = turn_bit ? LFS_FORK_RIGHT : LFS_FORK_LEFT;
               turn_index_in = turn_index_ff + 4'd1;
               holdoff_in    = '0;
            end else if (holdoff_ff != LFS_HOLD_SAT) begin
               holdoff_in = holdoff_ff + 8'd1;
            end
         end

         if (line_seen != '0) begin
            // sensor priority: middle, right, left
            priority if (line_seen[LFS_SEEN_MIDDLE]) begin
               drive_v = LFS_DRV_FWD;
            end else if (line_seen[LFS_SEEN_RIGHT]) begin
               drive_v = LFS_DRV_RIGHT;
            end else begin
               drive_v = LFS_DRV_LEFT;
            end
            scan_armed_in  = 1'b1;
            scan_active_in = 1'b1;
         end else begin
            // blind scan, a fresh scan starts its time at the current item with a right swing
            if (scan_armed_ff) begin
               scan_armed_in = 1'b0;
               scan_start_in = now_ms;
            end
            priority if (((elapsed <= LFS_SCAN_SWING_LEFT)
                          || ((elapsed >= LFS_SCAN_SWING_RIGHT)
                              && (elapsed <= LFS_SCAN_SWING_END)))
                         && scan_active_ff) begin
               drive_v = LFS_DRV_RIGHT;
            end else if ((elapsed >= LFS_SCAN_SWING_LEFT)
                         && (elapsed <= LFS_SCAN_SWING_RIGHT) && scan_active_ff) begin
               drive_v = LFS_DRV_LEFT;
            end else if ((elapsed >= LFS_SCAN_STOP_LO) && (elapsed <= LFS_SCAN_STOP_HI)) begin
               scan_active_in = 1'b0;
               drive_v        = LFS_DRV_STOP;
            end else begin
               // gaps between the sweeps hold the last command
               drive_v = scan_armed_ff ? LFS_DRV_STOP : last_drive_ff;
            end
         end
      end else if (!scan_armed_ff) begin
         // standby re-arms a started scan
         scan_armed_in  = 1'b1;
         scan_active_in = 1'b1;
         scan_start_in  = '0;
      end

      last_drive_in  = drive_v;
      res.drive      = drive_v;
      res.fork_turn  = fork_v;
      res.route_done = cfg.route_enable && ({1'b0, turn_index_in} >= len_eff);
   end

   // state registers, updated once per item
   always_ff @(posedge clock) begin
      if (reset) begin
         scan_armed_ff  <= 1'b1;
         scan_active_ff <= 1'b1;
         scan_start_ff  <= '0;
         turn_index_ff  <= '0;
         holdoff_ff     <= '0;
         last_drive_ff  <= LFS_DRV_STOP;
      end else if (step) begin
         scan_armed_ff  <= scan_armed_in;
         scan_active_ff <= scan_active_in;
         scan_start_ff  <= scan_start_in;
         turn_index_ff  <= turn_index_in;
         holdoff_ff     <= holdoff_in;
         last_drive_ff  <= last_drive_in;
      end
   end

endmodule

// ===== src/line_follow_steering_top.sv =====
// top level of the line follow steering block
// a request is held in the input register, then its response in the output register
// throughput: one item per cycle while responses are taken, the core state updates in a single step per item
// the output register takes a new item in the cycle its old item is taken
// reset (synchronous, active high) clears both stages, the scan and route state
// and loads the register defaults
module line_follow_steering_top
   import lfs_pkg::*;
(
   input  logic                      clock,
   input  logic                      reset,
   // request channel
   input  logic                      req_tvalid,
   output logic                      req_tready,
   input  logic [LFS_REQ_W-1:0]      req_tdata,  // right_level, middle_level, left_level, now_ms
   // response channel
   output logic                      rsp_tvalid,
   input  logic                      rsp_tready,
   output logic [LFS_RSP_W-1:0]      rsp_tdata,  // drive, fork_turn, route_done, line_seen
   // register write port
   input  logic                      csr_we,
   input  logic [LFS_CSR_IDX_W-1:0]  csr_index,
   input  logic [LFS_CSR_DATA_W-1:0] csr_wdata
);

   lfs_cfg_type          cfg_ff, cfg_in;
   logic                 in_valid_ff, in_valid_in;
   logic [LFS_REQ_W-1:0] in_data_ff;
   logic                 out_valid_ff, out_valid_in;
   logic [LFS_RSP_W-1:0] out_data_ff, out_data_in;
   logic                 advance;
   logic [2:0]           line_seen;
   lfs_result_type       res;

   // register writes
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         unique case (csr_index)
            LFS_CSR_DETECT_LOW:  cfg_in.detect_low      = csr_wdata;
            LFS_CSR_DETECT_HIGH: cfg_in.detect_high     = csr_wdata;
            LFS_CSR_TRACK_EN:    cfg_in.tracking_enable = csr_wdata[0];
            LFS_CSR_ROUTE_EN:    cfg_in.route_enable    = csr_wdata[0];
            LFS_CSR_ROUTE_LEN:   cfg_in.route_length    = csr_wdata[3:0];
            LFS_CSR_ROUTE_TURNS: cfg_in.route_turns     = csr_wdata[7:0];
            LFS_CSR_HOLDOFF:     cfg_in.fork_holdoff    = csr_wdata[7:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.detect_low      <= LFS_RST_DETECT_LOW;
         cfg_ff.detect_high     <= LFS_RST_DETECT_HIGH;
         cfg_ff.tracking_enable <= 1'b0;
         cfg_ff.route_enable    <= 1'b0;
         cfg_ff.route_length    <= LFS_RST_ROUTE_LEN;
         cfg_ff.route_turns     <= LFS_RST_ROUTE_TURNS;
         cfg_ff.fork_holdoff    <= LFS_RST_HOLDOFF;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // stage handshake: the input item moves when the output register is free
   assign advance      = in_valid_ff && (!out_valid_ff || rsp_tready);
   assign req_tready   = !in_valid_ff || advance;
   assign in_valid_in  = (req_tvalid && req_tready) ? 1'b1 : (advance ? 1'b0 : in_valid_ff);
   assign out_valid_in = advance ? 1'b1 : (rsp_tready ? 1'b0 : out_valid_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (req_tvalid && req_tready) begin
         in_data_ff <= req_tdata;
      end
      if (advance) begin
         out_data_ff <= out_data_in;
      end
   end

   lfs_window u_window (
      .right_level  (in_data_ff[LFS_REQ_RIGHT_LO +: LFS_LEVEL_W]),
      .middle_level (in_data_ff[LFS_REQ_MIDDLE_LO +: LFS_LEVEL_W]),
      .left_level   (in_data_ff[LFS_REQ_LEFT_LO +: LFS_LEVEL_W]),
      .detect_low   (cfg_ff.detect_low),
      .detect_high  (cfg_ff.detect_high),
      .line_seen    (line_seen)
   );

   lfs_core u_core (
      .clock     (clock),
      .reset     (reset),
      .step      (advance),
      .line_seen (line_seen),
      .now_ms    (in_data_ff[LFS_REQ_NOW_LO +: LFS_TIME_W]),
      .cfg       (cfg_ff),
      .res       (res)
   );

   // pack the response item
   always_comb begin
      out_data_in = '0;
      out_data_in[LFS_RSP_DRIVE_LO +: 2] = res.drive;
      out_data_in[LFS_RSP_FORK_LO +: 2]  = res.fork_turn;
      out_data_in[LFS_RSP_DONE_BIT]      = res.route_done;
      out_data_in[LFS_RSP_SEEN_LO +: 3]  = line_seen;
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = out_data_ff;

endmodule

// ===== src/lfs_checker.sv =====
// port level checks of the line follow steering block
`include "line_follow_steering_top_macros.svh"

module lfs_checker
   import lfs_pkg::*;
(
   input logic                 clock,
   input logic                 reset,
   input logic                 req_tvalid,
   input logic                 req_tready,
   input logic                 rsp_tvalid,
   input logic                 rsp_tready,
   input logic [LFS_RSP_W-1:0] rsp_tdata
);

   logic [1:0] drive_w;
   logic [1:0] fork_w;
   logic [2:0] seen_w;
   logic       req_idle;

   assign drive_w  = rsp_tdata[LFS_RSP_DRIVE_LO +: 2];
   assign fork_w   = rsp_tdata[LFS_RSP_FORK_LO +: 2];
   assign seen_w   = rsp_tdata[LFS_RSP_SEEN_LO +: 3];
   assign req_idle = !req_tvalid || req_tready;

   // no response item right after reset
   `LFS_ASSERT_SAME(a_rst_empty, clock, 1'b0, $past(reset) && req_idle, !rsp_tvalid, "response valid after reset")

   // a stalled response item holds
   `LFS_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_tvalid && !rsp_tready, rsp_tvalid && $stable(rsp_tdata), "stalled response changed")

   // a fork turn needs both outer sensors on the line
   `LFS_ASSERT_SAME(a_fork_seen, clock, reset, rsp_tvalid && (fork_w != LFS_FORK_NONE), seen_w[LFS_SEEN_LEFT] && seen_w[LFS_SEEN_RIGHT], "fork turn without both outer sensors")

   // the middle sensor wins whenever the car moves
   `LFS_ASSERT_SAME(a_mid_fwd, clock, reset, rsp_tvalid && seen_w[LFS_SEEN_MIDDLE] && (drive_w != LFS_DRV_STOP), drive_w == LFS_DRV_FWD, "middle on line but not forward")

endmodule

bind line_follow_steering_top lfs_checker u_lfs_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);

// ===== bench/tb_line_follow_steering_top.sv =====
// self-checking testbench for the line follow steering top level
`timescale 1ns / 100ps

module tb_line_follow_steering_top;
   import lfs_pkg::*;

   // one response item as it sits on rsp_tdata
   typedef struct packed {
      logic [2:0] seen;
      logic       done;
      logic [1:0] fork_turn;
      logic [1:0] drive;
   } steer_rsp_type;

   typedef enum logic {ROW_CFG, ROW_ITEM} row_kind_type;

   // one line of the directed plan: a register write or a sensor item
   typedef struct packed {
      row_kind_type             kind;
      logic [LFS_CSR_IDX_W-1:0] idx;
      logic [9:0]               val;
      logic [9:0]               lvl_r;
      logic [9:0]               lvl_m;
      logic [9:0]               lvl_l;
      logic [31:0]              now;
      logic                     chk;
      steer_rsp_type            want;
   } plan_row_type;

   // kinds of random segments
   localparam int SEG_TRACK = 0;
   localparam int SEG_LOST  = 1;
   localparam int SEG_FORK  = 2;
   localparam int SEG_NOISE = 3;
   localparam int PLAN_LEN  = 36;
   localparam int PHASES    = 10;

   logic                      clock;
   logic                      reset;
   logic                      req_tvalid;
   logic                      req_tready;
   logic [LFS_REQ_W-1:0]      req_tdata;
   logic                      rsp_tvalid;
   logic                      rsp_tready = 1'b0;
   logic [LFS_RSP_W-1:0]      rsp_tdata;
   logic                      csr_we;
   logic [LFS_CSR_IDX_W-1:0]  csr_index;
   logic [LFS_CSR_DATA_W-1:0] csr_wdata;

   // register copy of the steering model
   logic [9:0] cf_low   = LFS_RST_DETECT_LOW;
   logic [9:0] cf_high  = LFS_RST_DETECT_HIGH;
   logic       cf_track = 1'b0;
   logic       cf_route = 1'b0;
   logic [3:0] cf_len   = LFS_RST_ROUTE_LEN;
   logic [7:0] cf_turns = LFS_RST_ROUTE_TURNS;
   logic [7:0] cf_hold  = LFS_RST_HOLDOFF;

   // scan and route state of the steering model
   logic        scan_armed  = 1'b1;
   logic        scan_active = 1'b1;
   logic [31:0] scan_start  = '0;
   logic [3:0]  turn_idx    = '0;
   logic [7:0]  hold_cnt    = '0;
   logic [1:0]  last_drive  = LFS_DRV_STOP;

   steer_rsp_type steer_due [$];
   plan_row_type  plan [PLAN_LEN];
   int         mismatches = 0;
   int         burst_left = 0;
   logic [15:0] ready_mask = 16'hFFFF;
   int         mask_age = 0;

   line_follow_steering_top uut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   function automatic logic in_window(logic [9:0] v);
      return cf_low <= v && v <= cf_high;
   endfunction

   // next steering decision, updates the scan and route state
   function automatic steer_rsp_type steer_next(logic [9:0] rl, logic [9:0] ml,
                                                logic [9:0] ll, logic [31:0] now);
      logic          r, m, l;
      logic [3:0]    len_eff;
      logic [31:0]   el;
      steer_rsp_type res;
      r = in_window(rl);
      m = in_window(ml);
      l = in_window(ll);
      len_eff = (cf_len > 4'(LFS_ROUTE_MAX)) ? 4'(LFS_ROUTE_MAX) : cf_len;
      res = '0;
      res.drive = LFS_DRV_STOP;
      res.fork_turn = LFS_FORK_NONE;
      if (cf_track) begin
         // fork: both outer sensors on the line while turns remain
         if (cf_route && turn_idx < len_eff && l && r) begin
            if (hold_cnt > cf_hold) begin
               res.fork_turn = (turn_idx < 4'd8 && cf_turns[turn_idx[2:0]]) ?
                               LFS_FORK_RIGHT : LFS_FORK_LEFT;
               turn_idx = turn_idx + 1'b1;
               hold_cnt = '0;
            end else if (hold_cnt != LFS_HOLD_SAT) begin
               hold_cnt = hold_cnt + 1'b1;
            end
         end
         if (m || r || l) begin
            res.drive = m ? LFS_DRV_FWD : (r ? LFS_DRV_RIGHT : LFS_DRV_LEFT);
            scan_armed = 1'b1;
            scan_active = 1'b1;
         end else begin
            // blind scan, elapsed time wraps at 32 bits
            if (scan_armed) begin
               scan_armed = 1'b0;
               scan_start = now;
               last_drive = LFS_DRV_STOP;
            end
            el = now - scan_start;
            res.drive = last_drive;
            if ((el <= LFS_SCAN_SWING_LEFT ||
                 (el >= LFS_SCAN_SWING_RIGHT && el <= LFS_SCAN_SWING_END)) && scan_active)
               res.drive = LFS_DRV_RIGHT;
            else if (el >= LFS_SCAN_SWING_LEFT && el <= LFS_SCAN_SWING_RIGHT && scan_active)
               res.drive = LFS_DRV_LEFT;
            else if (el >= LFS_SCAN_STOP_LO && el <= LFS_SCAN_STOP_HI) begin
               scan_active = 1'b0;
               res.drive = LFS_DRV_STOP;
            end
         end
      end else if (!scan_armed) begin
         // standby re-arms a started scan
         scan_active = 1'b1;
         scan_armed = 1'b1;
         scan_start = '0;
      end
      last_drive = res.drive;
      res.done = cf_route && turn_idx >= len_eff;
      res.seen = {l, m, r};
      return res;
   endfunction

   // sensor level inside or outside the current window, edges now and then
   function automatic logic [9:0] pick_level(bit on);
      if (cf_low > cf_high)
         return 10'($urandom);
      if (on) begin
         case ($urandom_range(3, 0))
            0: return cf_low;
            1: return cf_high;
            default: return 10'($urandom_range(cf_high, cf_low));
         endcase
      end
      if (cf_low != 10'd0 && (cf_high == 10'h3FF || $urandom_range(1, 0) == 0))
         return $urandom_range(1, 0) ? cf_low - 1'b1 : 10'($urandom_range(cf_low - 1, 0));
      if (cf_high != 10'h3FF)
         return $urandom_range(1, 0) ? cf_high + 1'b1 : 10'($urandom_range(1023, cf_high + 1));
      return 10'($urandom);
   endfunction

   function automatic plan_row_type cfg_row(logic [LFS_CSR_IDX_W-1:0] idx, logic [9:0] val);
      plan_row_type row;
      row = '0;
      row.kind = ROW_CFG;
      row.idx = idx;
      row.val = val;
      return row;
   endfunction

   function automatic plan_row_type item_row(logic [9:0] rl, logic [9:0] ml, logic [9:0] ll,
                                             logic [31:0] now);
      plan_row_type row;
      row = '0;
      row.kind = ROW_ITEM;
      row.lvl_r = rl;
      row.lvl_m = ml;
      row.lvl_l = ll;
      row.now = now;
      return row;
   endfunction

   function automatic plan_row_type item_chk(logic [9:0] rl, logic [9:0] ml, logic [9:0] ll,
                                             logic [31:0] now, logic [1:0] drv, logic [1:0] fk,
                                             logic done, logic [2:0] seen);
      plan_row_type row;
      row = item_row(rl, ml, ll, now);
      row.chk = 1'b1;
      row.want.drive = drv;
      row.want.fork_turn = fk;
      row.want.done = done;
      row.want.seen = seen;
      return row;
   endfunction

   task automatic report_error(string msg);
      if (mismatches < 30)
         $display("%0t: %s", $time, msg);
      mismatches++;
   endtask

   task automatic check_field(string name, int got, int want);
      if (got != want)
         report_error($sformatf("%s got %0d expected %0d", name, got, want));
   endtask

   // register write, mirrored into the model copy at the write edge
   task automatic write_reg(logic [LFS_CSR_IDX_W-1:0] idx, logic [9:0] val);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(posedge clock);
      case (idx)
         LFS_CSR_DETECT_LOW:  cf_low = val;
         LFS_CSR_DETECT_HIGH: cf_high = val;
         LFS_CSR_TRACK_EN:    cf_track = val[0];
         LFS_CSR_ROUTE_EN:    cf_route = val[0];
         LFS_CSR_ROUTE_LEN:   cf_len = val[3:0];
         LFS_CSR_ROUTE_TURNS: cf_turns = val[7:0];
         LFS_CSR_HOLDOFF:     cf_hold = val[7:0];
         default: ;
      endcase
   endtask

   // wait until every response is back and the pipeline is empty
   task automatic settle();
      req_tvalid <= 1'b0;
      csr_we <= 1'b0;
      while (steer_due.size() != 0)
         @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   // send one sensor item in bursts with random gaps
   task automatic send_sample(logic [9:0] rl, logic [9:0] ml, logic [9:0] ll,
                              logic [31:0] now, logic chk, steer_rsp_type want);
      int            gap;
      steer_rsp_type calc;
      gap = 0;
      if (burst_left == 0) begin
         burst_left = $urandom_range(24, 1);
         gap = ($urandom_range(3, 0) == 0) ? 0 : $urandom_range(8, 1);
      end
      burst_left--;
      if (csr_we)
         csr_we <= 1'b0;
      if (gap != 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata <= {2'b00, now, ll, ml, rl};
      do @(posedge clock); while (!req_tready);
      calc = steer_next(rl, ml, ll, now);
      steer_due.push_back(chk ? want : calc);
   endtask

   // response ready follows a rotating pattern, reloaded at random whenever mask_age wraps
   always @(posedge clock) begin
      if (mask_age == 63) begin
         case ($urandom_range(3, 0))
            0: ready_mask <= 16'hFFFF;
            1: ready_mask <= 16'($urandom);
            2: ready_mask <= 16'($urandom & $urandom);
            default: ready_mask <= 16'($urandom | $urandom);
         endcase
      end else begin
         ready_mask <= {ready_mask[0], ready_mask[15:1]};
      end
      mask_age <= (mask_age + 1) % 64;
      rsp_tready <= ready_mask[0];
   end

   // compare each response item with the oldest expected decision
   always @(posedge clock) begin : rsp_check
      steer_rsp_type got, want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got = rsp_tdata;
         if (steer_due.size() == 0) begin
            report_error("response item with nothing expected");
         end else begin
            want = steer_due.pop_front();
            check_field("drive", int'(got.drive), int'(want.drive));
            check_field("fork_turn", int'(got.fork_turn), int'(want.fork_turn));
            check_field("route_done", int'(got.done), int'(want.done));
            check_field("line_seen", int'(got.seen), int'(want.seen));
         end
      end
   end

   initial begin : stimulus
      int          p, n, n_items, seg_left, seg_kind, roll;
      logic [31:0] cursor, step;
      logic [9:0]  lo, hi, rl, ml, ll;
      logic [3:0]  len;
      logic [7:0]  turns, hold;
      logic        track, route;
      bit          on_r, on_m, on_l, prev_cfg;

      reset = 1'b1;
      req_tvalid = 1'b0;
      req_tdata = '0;
      csr_we = 1'b0;
      csr_index = '0;
      csr_wdata = '0;

      plan = '{
         // defaults after reset: standby, full window
         item_chk(10'd0, 10'd0, 10'd0, 32'd0, LFS_DRV_STOP, LFS_FORK_NONE, 1'b0, 3'd7),
         item_chk(10'd1023, 10'd1023, 10'd1023, 32'hFFFF_FFFF,
                  LFS_DRV_STOP, LFS_FORK_NONE, 1'b0, 3'd7),
         // tracking with window 100..900, sensor priority
         cfg_row(LFS_CSR_TRACK_EN, 10'd1),
         cfg_row(LFS_CSR_DETECT_LOW, 10'd100),
         cfg_row(LFS_CSR_DETECT_HIGH, 10'd900),
         item_chk(10'd100, 10'd900, 10'd0, 32'd10, LFS_DRV_FWD, LFS_FORK_NONE, 1'b0, 3'd3),
         item_chk(10'd0, 10'd901, 10'd100, 32'd20, LFS_DRV_LEFT, LFS_FORK_NONE, 1'b0, 3'd4),
         item_chk(10'd900, 10'd99, 10'd1023, 32'd30, LFS_DRV_RIGHT, LFS_FORK_NONE, 1'b0, 3'd1),
         // line lost: blind scan through its time boundaries
         item_chk(10'd0, 10'd0, 10'd0, 32'd1000, LFS_DRV_RIGHT, LFS_FORK_NONE, 1'b0, 3'd0),
         item_row(10'd99, 10'd901, 10'd1023, 32'd1200),
         item_row(10'd99, 10'd901, 10'd1023, 32'd1201),
         item_row(10'd1023, 10'd0, 10'd99, 32'd2600),
         item_row(10'd0, 10'd0, 10'd0, 32'd3001),
         item_row(10'd0, 10'd0, 10'd0, 32'd4000),
         item_row(10'd0, 10'd0, 10'd0, 32'd4201),
         item_row(10'd0, 10'd0, 10'd0, 32'd4600),
         item_chk(10'd500, 10'd500, 10'd500, 32'd5000, LFS_DRV_FWD, LFS_FORK_NONE, 1'b0, 3'd7),
         // scan across the 32-bit time wrap
         item_row(10'd0, 10'd0, 10'd0, 32'hFFFF_FF00),
         item_row(10'd0, 10'd0, 10'd0, 32'h0000_0050),
         // inverted window detects nothing
         cfg_row(LFS_CSR_DETECT_LOW, 10'd600),
         cfg_row(LFS_CSR_DETECT_HIGH, 10'd500),
         item_row(10'd550, 10'd600, 10'd500, 32'h0000_0060),
         // route of two turns, right then left, no holdoff
         cfg_row(LFS_CSR_DETECT_LOW, 10'd0),
         cfg_row(LFS_CSR_DETECT_HIGH, 10'd511),
         cfg_row(LFS_CSR_ROUTE_EN, 10'd1),
         cfg_row(LFS_CSR_ROUTE_LEN, 10'd2),
         cfg_row(LFS_CSR_ROUTE_TURNS, 10'd1),
         cfg_row(LFS_CSR_HOLDOFF, 10'd0),
         item_row(10'd0, 10'd1023, 10'd0, 32'd100),
         item_row(10'd511, 10'd1023, 10'd511, 32'd110),
         item_row(10'd0, 10'd0, 10'd0, 32'd120),
         item_row(10'd0, 10'd0, 10'd0, 32'd130),
         item_row(10'd0, 10'd0, 10'd0, 32'd140),
         item_row(10'd1023, 10'd1023, 10'd1023, 32'd145),
         // standby re-arms the running scan, route done still shown
         cfg_row(LFS_CSR_TRACK_EN, 10'd0),
         item_chk(10'd1023, 10'd1023, 10'd1023, 32'd150,
                  LFS_DRV_STOP, LFS_FORK_NONE, 1'b1, 3'd0)
      };

      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // directed plan
      prev_cfg = 1'b0;
      for (n = 0; n < PLAN_LEN; n++) begin
         if (plan[n].kind == ROW_CFG) begin
            if (!prev_cfg)
               settle();
            write_reg(plan[n].idx, plan[n].val);
            prev_cfg = 1'b1;
         end else begin
            send_sample(plan[n].lvl_r, plan[n].lvl_m, plan[n].lvl_l, plan[n].now,
                        plan[n].chk, plan[n].want);
            prev_cfg = 1'b0;
         end
      end

      // random phases, each with its own register setting
      for (p = 0; p < PHASES; p++) begin
         settle();
         lo = 10'($urandom_range(400, 0));
         hi = 10'($urandom_range(1023, 500));
         track = 1'b1;
         route = 1'b1;
         len = 4'(turn_idx + $urandom_range(2, 0));
         turns = 8'($urandom);
         hold = 8'($urandom_range(6, 0));
         cursor = $urandom;
         case (p)
            0: begin
               lo = 10'd0;
               hi = 10'd1023;
               len = turn_idx + 1'b1;
               hold = 8'd0;
            end
            1: begin
               // holdoff at its top: forks count up and saturate, no turn
               lo = 10'd1023;
               hi = 10'd1023;
               len = 4'd15;
               turns = 8'd0;
               hold = 8'd255;
            end
            2: begin
               track = 1'b0;
               len = 4'($urandom_range(15, 0));
            end
            3: begin
               lo = 10'($urandom_range(1023, 513));
               hi = 10'($urandom_range(512, 0));
            end
            4: len = 4'd0;
            5: begin
               cursor = 32'hFFFF_F000 + $urandom_range(2047, 0);
               route = 1'b0;
            end
            9: begin
               len = 4'd15;
               turns = 8'hFF;
            end
            default: ;
         endcase
         write_reg(LFS_CSR_DETECT_LOW, lo);
         write_reg(LFS_CSR_DETECT_HIGH, hi);
         write_reg(LFS_CSR_TRACK_EN, 10'(track));
         write_reg(LFS_CSR_ROUTE_EN, 10'(route));
         write_reg(LFS_CSR_ROUTE_LEN, 10'(len));
         write_reg(LFS_CSR_ROUTE_TURNS, 10'(turns));
         write_reg(LFS_CSR_HOLDOFF, 10'(hold));

         n_items = (p == 1) ? 280 : 30;
         seg_left = 0;
         seg_kind = SEG_TRACK;
         for (n = 0; n < n_items; n++) begin
            // pick the next segment: tracking, lost line, fork or noise
            if (seg_left == 0) begin
               roll = $urandom_range(99, 0);
               if (p == 1 && n == 0)
                  seg_kind = SEG_FORK;
               else if (roll < 35)
                  seg_kind = SEG_TRACK;
               else if (roll < 65)
                  seg_kind = SEG_LOST;
               else if (roll < 85)
                  seg_kind = SEG_FORK;
               else
                  seg_kind = SEG_NOISE;
               case (seg_kind)
                  SEG_LOST: seg_left = $urandom_range(14, 4);
                  SEG_FORK: seg_left = (cf_hold == LFS_HOLD_SAT) ? 260 :
                                       cf_hold + $urandom_range(4, 1);
                  default:  seg_left = $urandom_range(8, 1);
               endcase
            end
            seg_left--;
            on_r = 1'($urandom_range(1, 0));
            on_m = 1'($urandom_range(1, 0));
            on_l = 1'($urandom_range(1, 0));
            step = $urandom_range(300, 0);
            case (seg_kind)
               SEG_LOST: begin
                  on_r = 1'b0;
                  on_m = 1'b0;
                  on_l = 1'b0;
                  step = $urandom_range(700, 30);
               end
               SEG_FORK: begin
                  on_r = 1'b1;
                  on_l = 1'b1;
                  step = $urandom_range(40, 0);
               end
               default: ;
            endcase
            cursor = cursor + step;
            rl = pick_level(on_r);
            ml = pick_level(on_m);
            ll = pick_level(on_l);
            if (seg_kind == SEG_NOISE)
               send_sample(10'($urandom), 10'($urandom), 10'($urandom), $urandom, 1'b0, '0);
            else
               send_sample(rl, ml, ll, cursor, 1'b0, '0);
         end
      end

      settle();
      if (mismatches == 0)
         $display("simulation ok");
      else
         $display("simulation failed");
      $finish;
   end

   // hard stop for a hung handshake
   initial begin : watchdog
      #4_000_000;
      $display("simulation failed");
      $finish;
   end

endmodule

// ===== sim.f =====
+incdir+src
src/lfs_pkg.sv
src/lfs_window.sv
src/lfs_core.sv
src/line_follow_steering_top.sv
src/lfs_checker.sv
bench/tb_line_follow_steering_top.sv
